>>> rtl/abps_pkg.sv
`timescale 1ns / 1ps

package abps_pkg;

    // Field and register widths
    localparam int ACT_W       = 16;
    localparam int COORD_W     = 16;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int GAIN_W      = 16;
    localparam int DIST_W      = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_ACTS    = 6;
    localparam int NUM_CTRL    = 3;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 40;

    // Behavior constants
    localparam int MAX_POINTS   = 64;
    localparam int MIN_POINTS   = 2;
    localparam bit CLIP_ACTIONS = 1'b1;
    localparam int Q_ONE        = 16384;
    localparam int GAIN_SHIFT   = 18;

    // Arithmetic widths of the sample path
    localparam int N3_W    = 19;
    localparam int WGT_W   = 19;
    localparam int PROD_W  = 36;
    localparam int SUM_W   = 38;
    localparam int NUM_W   = 34;
    localparam int QUO_W   = 16;

    // Register reset values
    localparam logic [CNT_W-1:0]  RST_POINT_COUNT = 7'd20;
    localparam logic [DIST_W-1:0] RST_ANCHOR_NEAR = 15'd410;
    localparam logic [DIST_W-1:0] RST_ANCHOR_MID  = 15'd1024;
    localparam logic [DIST_W-1:0] RST_ANCHOR_FAR  = 15'd1843;
    localparam logic [GAIN_W-1:0] RST_X_GAIN      = 16'd4096;
    localparam logic [GAIN_W-1:0] RST_LAT_GAIN    = 16'd13107;
    localparam logic [DIST_W-1:0] RST_MIN_GAP     = 15'd51;
    localparam logic [DIST_W-1:0] RST_MIN_FORWARD = 15'd51;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_COUNT = 3'd0,
        REG_ANCHOR_NEAR = 3'd1,
        REG_ANCHOR_MID  = 3'd2,
        REG_ANCHOR_FAR  = 3'd3,
        REG_X_GAIN      = 3'd4,
        REG_LAT_GAIN    = 3'd5,
        REG_MIN_GAP     = 3'd6,
        REG_MIN_FORWARD = 3'd7
    } t_reg_idx;

    // Saturate an 18-bit signed value to 16 bits
    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [17:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > 18'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/action_to_bezier_path_sampler_top.sv
`timescale 1ns / 1ps

// Action to cubic Bezier path sampler.
// Slave stream: one item carries six signed Q1.14 actions. Each accepted item
// is turned into three control points and then into point_count samples of
// the cubic Bezier from the origin, one sample per cycle on the master
// stream while tready is high, tlast on the final sample of the path.
// Configuration: a plain write port (enable, index, data); write only while
// the block is idle. Out-of-range indexes cannot occur with a 3-bit index.
// Structure: a control point pipeline, a load into the sample sequencer,
// and a 22-stage sample pipeline of which 16 stages are a one-bit-per-stage
// restoring divider.
// Throughput: one sample per cycle while the output is not stalled; an item
// keeps the input closed until the sample sequencer has issued its last
// sample. The next item is taken while earlier samples still drain.
// Reset: synchronous, active low; clears all valid bits and loads the
// register defaults. No clearing pass.
// Stall: when the receiver holds tready low, the whole sample pipeline holds;
// nothing is lost or repeated.
module action_to_bezier_path_sampler_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // act_x_near, act_y_near, act_x_mid, act_y_mid, act_x_far, act_y_far
    input  logic [abps_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // sample_index, pos_x, pos_y, zero padding
    output logic [abps_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_wr_en,
    input  logic [abps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [abps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import abps_pkg::*;

    localparam int FRONT_LEN  = 6;
    localparam int PRE_LEN    = 6;
    localparam int DIV_STAGES = QUO_W;
    localparam int PIPE_LEN   = PRE_LEN + DIV_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  r_point_count;
    logic [DIST_W-1:0] r_anchor_near;
    logic [DIST_W-1:0] r_anchor_mid;
    logic [DIST_W-1:0] r_anchor_far;
    logic [GAIN_W-1:0] r_x_gain;
    logic [GAIN_W-1:0] r_lat_gain;
    logic [DIST_W-1:0] r_min_gap;
    logic [DIST_W-1:0] r_min_forward;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= RST_POINT_COUNT;
            r_anchor_near <= RST_ANCHOR_NEAR;
            r_anchor_mid  <= RST_ANCHOR_MID;
            r_anchor_far  <= RST_ANCHOR_FAR;
            r_x_gain      <= RST_X_GAIN;
            r_lat_gain    <= RST_LAT_GAIN;
            r_min_gap     <= RST_MIN_GAP;
            r_min_forward <= RST_MIN_FORWARD;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_POINT_COUNT: r_point_count <= i_cfg_data[CNT_W-1:0];
                REG_ANCHOR_NEAR: r_anchor_near <= i_cfg_data[DIST_W-1:0];
                REG_ANCHOR_MID:  r_anchor_mid  <= i_cfg_data[DIST_W-1:0];
                REG_ANCHOR_FAR:  r_anchor_far  <= i_cfg_data[DIST_W-1:0];
                REG_X_GAIN:      r_x_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_LAT_GAIN:    r_lat_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_MIN_GAP:     r_min_gap     <= i_cfg_data[DIST_W-1:0];
                REG_MIN_FORWARD: r_min_forward <= i_cfg_data[DIST_W-1:0];
                default:         r_point_count <= r_point_count;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input handshake: one item in flight until its last sample is issued
    // ------------------------------------------------------------------
    logic r_busy;
    logic w_accept;
    logic w_adv;
    logic w_issue;
    logic w_issue_last;

    logic                r_seq_act;
    logic [CNT_W-1:0]    r_k;
    logic [CNT_W-1:0]    r_n;

    assign o_s_axis_tready = !r_busy;
    assign w_accept        = i_s_axis_tvalid && !r_busy;
    assign w_issue         = r_seq_act && w_adv;
    assign w_issue_last    = w_issue && (r_k == r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_issue_last) begin
            r_busy <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control point pipeline (one item at a time, never stalls)
    // ------------------------------------------------------------------
    logic [FRONT_LEN-1:0] r_fv;

    logic signed [ACT_W-1:0]   w_clip [NUM_ACTS];
    logic [CNT_W-1:0]          w_n_eff;

    logic signed [ACT_W-1:0]   r_f0_act [NUM_ACTS];
    logic [CNT_W-1:0]          r_f0_n;
    logic signed [32:0]        r_f1_prod [NUM_ACTS];
    logic [CNT_W-1:0]          r_f1_n;
    logic [13:0]               r_f1_n2;
    logic signed [COORD_W-1:0] r_f2_off [NUM_ACTS];
    logic [CNT_W-1:0]          r_f2_n;
    logic [N3_W-1:0]           r_f2_n3;
    logic signed [COORD_W-1:0] r_f3_x1;
    logic signed [COORD_W-1:0] r_f3_off [NUM_ACTS];
    logic [CNT_W-1:0]          r_f3_n;
    logic [N3_W-1:0]           r_f3_n3;
    logic signed [COORD_W-1:0] r_f4_x1;
    logic signed [COORD_W-1:0] r_f4_x2;
    logic signed [COORD_W-1:0] r_f4_off [NUM_ACTS];
    logic [CNT_W-1:0]          r_f4_n;
    logic [N3_W-1:0]           r_f4_n3;
    logic signed [COORD_W-1:0] r_f5_cp [NUM_ACTS];
    logic [CNT_W-1:0]          r_f5_n;
    logic [N3_W-1:0]           r_f5_n3;

    logic signed [17:0] w_c1;
    logic signed [17:0] w_c2;
    logic signed [17:0] w_c3;
    logic signed [17:0] w_fl2;
    logic signed [17:0] w_fl3;
    logic signed [17:0] w_min_fwd;

    // Clip actions and clamp the sample count
    always_comb begin
        for (int i = 0; i < NUM_ACTS; i++) begin
            w_clip[i] = $signed(i_s_axis_tdata[ACT_W*i +: ACT_W]);
            if (CLIP_ACTIONS) begin
                if (w_clip[i] > 16'sd16384) begin
                    w_clip[i] = 16'sd16384;
                end else if (w_clip[i] < -16'sd16384) begin
                    w_clip[i] = -16'sd16384;
                end
            end
        end
        if (r_point_count < CNT_W'(MIN_POINTS)) begin
            w_n_eff = CNT_W'(MIN_POINTS);
        end else if (r_point_count > CNT_W'(MAX_POINTS)) begin
            w_n_eff = CNT_W'(MAX_POINTS);
        end else begin
            w_n_eff = r_point_count;
        end
    end

    // Control x chain: floor against min_forward or the previous x plus gap
    assign w_min_fwd = $signed({3'b000, r_min_forward});
    assign w_c1  = $signed({3'b000, r_anchor_near}) + 18'(r_f2_off[0]);
    assign w_c2  = $signed({3'b000, r_anchor_mid})  + 18'(r_f3_off[2]);
    assign w_fl2 = 18'(r_f3_x1) + $signed({3'b000, r_min_gap});
    assign w_c3  = $signed({3'b000, r_anchor_far})  + 18'(r_f4_off[4]);
    assign w_fl3 = 18'(r_f4_x2) + $signed({3'b000, r_min_gap});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else begin
            r_fv <= {r_fv[FRONT_LEN-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        // capture clipped actions
        if (w_accept) begin
            for (int i = 0; i < NUM_ACTS; i++) begin
                r_f0_act[i] <= w_clip[i];
            end
            r_f0_n <= w_n_eff;
        end
        // gain products and N squared
        for (int i = 0; i < NUM_ACTS; i++) begin
            r_f1_prod[i] <= r_f0_act[i] *
                            $signed({1'b0, (i[0] ? r_lat_gain : r_x_gain)});
        end
        r_f1_n  <= r_f0_n;
        r_f1_n2 <= 14'(r_f0_n * r_f0_n);
        // round products to Q5.10, N cubed
        for (int i = 0; i < NUM_ACTS; i++) begin
            r_f2_off[i] <= 16'((r_f1_prod[i] + 33'sd131072) >>> GAIN_SHIFT);
        end
        r_f2_n  <= r_f1_n;
        r_f2_n3 <= N3_W'(r_f1_n2 * r_f1_n);
        // first control x
        r_f3_x1  <= sat16((w_c1 < w_min_fwd) ? w_min_fwd : w_c1);
        r_f3_off <= r_f2_off;
        r_f3_n   <= r_f2_n;
        r_f3_n3  <= r_f2_n3;
        // second control x
        r_f4_x1  <= r_f3_x1;
        r_f4_x2  <= sat16((w_c2 < w_fl2) ? w_fl2 : w_c2);
        r_f4_off <= r_f3_off;
        r_f4_n   <= r_f3_n;
        r_f4_n3  <= r_f3_n3;
        // third control x, assemble the control points
        r_f5_cp[0] <= r_f4_x1;
        r_f5_cp[1] <= r_f4_off[1];
        r_f5_cp[2] <= r_f4_x2;
        r_f5_cp[3] <= r_f4_off[3];
        r_f5_cp[4] <= sat16((w_c3 < w_fl3) ? w_fl3 : w_c3);
        r_f5_cp[5] <= r_f4_off[5];
        r_f5_n     <= r_f4_n;
        r_f5_n3    <= r_f4_n3;
    end

    // ------------------------------------------------------------------
    // Sample sequencer: issue k = 1..N, one per advancing cycle
    // ------------------------------------------------------------------
    logic [N3_W-1:0]           r_seq_n3;
    logic signed [COORD_W-1:0] r_seq_cp [NUM_ACTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_act <= 1'b0;
        end else if (r_fv[FRONT_LEN-1]) begin
            r_seq_act <= 1'b1;
        end else if (w_issue_last) begin
            r_seq_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fv[FRONT_LEN-1]) begin
            r_k      <= CNT_W'(1);
            r_n      <= r_f5_n;
            r_seq_n3 <= r_f5_n3;
            r_seq_cp <= r_f5_cp;
        end else if (w_issue) begin
            r_k <= r_k + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Sample pipeline, stalled as a whole by the output
    // ------------------------------------------------------------------
    logic [PIPE_LEN-1:0] r_pv;

    assign w_adv = !r_pv[PIPE_LEN-1] || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_adv) begin
            r_pv <= {r_pv[PIPE_LEN-2:0], w_issue};
        end
    end

    // Sidebands through the pre-divide stages
    logic [IDX_W-1:0]          r_pre_idx  [PRE_LEN];
    logic                      r_pre_last [PRE_LEN];
    logic [N3_W-1:0]           r_pre_n3   [PRE_LEN];

    logic [CNT_W-1:0]          r_p0_k;
    logic [CNT_W-1:0]          r_p0_r;
    logic signed [COORD_W-1:0] r_p0_cp [NUM_ACTS];
    logic [12:0]               r_p1_kk;
    logic [11:0]               r_p1_rr;
    logic [CNT_W-1:0]          r_p1_k;
    logic [CNT_W-1:0]          r_p1_r;
    logic signed [COORD_W-1:0] r_p1_cp [NUM_ACTS];
    logic [WGT_W-1:0]          r_p2_b [NUM_CTRL];
    logic signed [COORD_W-1:0] r_p2_cp [NUM_ACTS];
    logic signed [PROD_W-1:0]  r_p3_prod [NUM_ACTS];
    logic signed [SUM_W-1:0]   r_p4_sum_x;
    logic signed [SUM_W-1:0]   r_p4_sum_y;
    logic [NUM_W-1:0]          r_p5_num_x;
    logic [NUM_W-1:0]          r_p5_num_y;

    logic [WGT_W-1:0]          w_rrk;
    logic [WGT_W-1:0]          w_kkr;
    logic signed [SUM_W-1:0]   w_bias;
    logic signed [SUM_W-1:0]   w_num_x;
    logic signed [SUM_W-1:0]   w_num_y;

    // Bernstein weights times N cubed: 3r^2k, 3rk^2, k^3
    assign w_rrk = WGT_W'(r_p1_rr * r_p1_k);
    assign w_kkr = WGT_W'(r_p1_kk * r_p1_r);

    // Offset so the dividend is never negative, plus the rounding half
    assign w_bias  = $signed({4'b0000, r_pre_n3[4], 15'd0}) +
                     $signed({20'd0, r_pre_n3[4][N3_W-1:1]});
    assign w_num_x = r_p4_sum_x + w_bias;
    assign w_num_y = r_p4_sum_y + w_bias;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // issue
            r_pre_idx[0]  <= IDX_W'(r_k - CNT_W'(1));
            r_pre_last[0] <= (r_k == r_n);
            r_pre_n3[0]   <= r_seq_n3;
            r_p0_k        <= r_k;
            r_p0_r        <= r_n - r_k;
            r_p0_cp       <= r_seq_cp;
            for (int s = 1; s < PRE_LEN; s++) begin
                r_pre_idx[s]  <= r_pre_idx[s-1];
                r_pre_last[s] <= r_pre_last[s-1];
                r_pre_n3[s]   <= r_pre_n3[s-1];
            end
            // squares
            r_p1_kk <= 13'(r_p0_k * r_p0_k);
            r_p1_rr <= 12'(r_p0_r * r_p0_r);
            r_p1_k  <= r_p0_k;
            r_p1_r  <= r_p0_r;
            r_p1_cp <= r_p0_cp;
            // weights
            r_p2_b[0] <= w_rrk + {w_rrk[WGT_W-2:0], 1'b0};
            r_p2_b[1] <= w_kkr + {w_kkr[WGT_W-2:0], 1'b0};
            r_p2_b[2] <= WGT_W'(r_p1_kk * r_p1_k);
            r_p2_cp   <= r_p1_cp;
            // weight times control coordinate
            for (int i = 0; i < NUM_ACTS; i++) begin
                r_p3_prod[i] <= $signed({1'b0, r_p2_b[i>>1]}) * r_p2_cp[i];
            end
            // sum per coordinate
            r_p4_sum_x <= SUM_W'(r_p3_prod[0]) + SUM_W'(r_p3_prod[2]) +
                          SUM_W'(r_p3_prod[4]);
            r_p4_sum_y <= SUM_W'(r_p3_prod[1]) + SUM_W'(r_p3_prod[3]) +
                          SUM_W'(r_p3_prod[5]);
            // biased dividend
            r_p5_num_x <= w_num_x[NUM_W-1:0];
            r_p5_num_y <= w_num_y[NUM_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider by N cubed, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  r_d_rem_x [DIV_STAGES];
    logic [NUM_W-1:0]  r_d_rem_y [DIV_STAGES];
    logic [QUO_W-1:0]  r_d_q_x   [DIV_STAGES];
    logic [QUO_W-1:0]  r_d_q_y   [DIV_STAGES];
    logic [N3_W-1:0]   r_d_n3    [DIV_STAGES];
    logic [IDX_W-1:0]  r_d_idx   [DIV_STAGES];
    logic              r_d_last  [DIV_STAGES];

    logic [NUM_W-1:0]  w_src_rem_x [DIV_STAGES];
    logic [NUM_W-1:0]  w_src_rem_y [DIV_STAGES];
    logic [QUO_W-1:0]  w_src_q_x   [DIV_STAGES];
    logic [QUO_W-1:0]  w_src_q_y   [DIV_STAGES];
    logic [N3_W-1:0]   w_src_n3    [DIV_STAGES];
    logic [IDX_W-1:0]  w_src_idx   [DIV_STAGES];
    logic              w_src_last  [DIV_STAGES];
    logic [NUM_W-1:0]  w_dvs       [DIV_STAGES];

    // Stage inputs: the biased dividend, then the previous stage
    always_comb begin
        w_src_rem_x[0] = r_p5_num_x;
        w_src_rem_y[0] = r_p5_num_y;
        w_src_q_x[0]   = '0;
        w_src_q_y[0]   = '0;
        w_src_n3[0]    = r_pre_n3[PRE_LEN-1];
        w_src_idx[0]   = r_pre_idx[PRE_LEN-1];
        w_src_last[0]  = r_pre_last[PRE_LEN-1];
        for (int j = 1; j < DIV_STAGES; j++) begin
            w_src_rem_x[j] = r_d_rem_x[j-1];
            w_src_rem_y[j] = r_d_rem_y[j-1];
            w_src_q_x[j]   = r_d_q_x[j-1];
            w_src_q_y[j]   = r_d_q_y[j-1];
            w_src_n3[j]    = r_d_n3[j-1];
            w_src_idx[j]   = r_d_idx[j-1];
            w_src_last[j]  = r_d_last[j-1];
        end
        for (int j = 0; j < DIV_STAGES; j++) begin
            w_dvs[j] = NUM_W'(w_src_n3[j]) << (DIV_STAGES - 1 - j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                if (w_src_rem_x[j] >= w_dvs[j]) begin
                    r_d_rem_x[j] <= w_src_rem_x[j] - w_dvs[j];
                    r_d_q_x[j]   <= {w_src_q_x[j][QUO_W-2:0], 1'b1};
                end else begin
                    r_d_rem_x[j] <= w_src_rem_x[j];
                    r_d_q_x[j]   <= {w_src_q_x[j][QUO_W-2:0], 1'b0};
                end
                if (w_src_rem_y[j] >= w_dvs[j]) begin
                    r_d_rem_y[j] <= w_src_rem_y[j] - w_dvs[j];
                    r_d_q_y[j]   <= {w_src_q_y[j][QUO_W-2:0], 1'b1};
                end else begin
                    r_d_rem_y[j] <= w_src_rem_y[j];
                    r_d_q_y[j]   <= {w_src_q_y[j][QUO_W-2:0], 1'b0};
                end
                r_d_n3[j]   <= w_src_n3[j];
                r_d_idx[j]  <= w_src_idx[j];
                r_d_last[j] <= w_src_last[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: remove the offset of half the 16-bit range
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] w_pos_x;
    logic [COORD_W-1:0] w_pos_y;

    assign w_pos_x = {~r_d_q_x[DIV_STAGES-1][QUO_W-1], r_d_q_x[DIV_STAGES-1][QUO_W-2:0]};
    assign w_pos_y = {~r_d_q_y[DIV_STAGES-1][QUO_W-1], r_d_q_y[DIV_STAGES-1][QUO_W-2:0]};

    assign o_m_axis_tvalid = r_pv[PIPE_LEN-1];
    assign o_m_axis_tlast  = r_d_last[DIV_STAGES-1];
    assign o_m_axis_tdata  = {2'b00, w_pos_y, w_pos_x, r_d_idx[DIV_STAGES-1]};

`ifndef SYNTHESIS
    // A finished control point set never lands on an active sequencer
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv[FRONT_LEN-1] |-> !r_seq_act)
        else $error("control points loaded while sequencer active");

    // At most one item in the control point pipeline
    a_front_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_fv))
        else $error("more than one item in control point pipeline");

    // The input stays closed while samples are still to be issued
    a_busy_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_act || (r_fv != '0)) |-> r_busy)
        else $error("input open while an item is in progress");

    // Sample number stays inside the path
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_act |-> (r_k >= CNT_W'(1)) && (r_k <= r_n))
        else $error("sample number out of range");

    // Issuing the last sample ends the sequence
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue_last |=> !r_seq_act && !r_busy)
        else $error("sequencer did not stop after last sample");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import abps_pkg::*;

    // One path sample as it leaves the block
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_sample;

    // Raw register words, indexed by register code
    typedef logic [7:0][CFG_DATA_W-1:0] t_cfg_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Shadow registers, queued samples and traffic shaping
    logic [CFG_DATA_W-1:0]  reg_val [8];
    t_sample                path_queue [$];
    int                     error_count = 0;
    int                     send_idle_pct = 16;
    int                     stall_pct = 16;
    int                     hold_off_left = 0;

    action_to_bezier_path_sampler_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Path arithmetic
    // ---------------------------------------------------------------

    // Divide and round to nearest, halves toward +inf (d > 0)
    function automatic longint round_div(input longint n, input longint d);
        longint m;
        m = n + d / 2;
        if (m >= 0) begin
            return m / d;
        end
        return -((-m + d - 1) / d);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic longint reg_num(input t_reg_idx r);
        return longint'(reg_val[r]);
    endfunction

    // Q1.14 action times Q2.14 gain, down to Q5.10
    function automatic longint scale_action(input longint a, input t_reg_idx gain_reg);
        return round_div(a * reg_num(gain_reg), longint'(1) << GAIN_SHIFT);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_mask(input int r);
        case (r)
            REG_POINT_COUNT: return CFG_DATA_W'((1 << CNT_W) - 1);
            REG_X_GAIN, REG_LAT_GAIN: return CFG_DATA_W'((1 << GAIN_W) - 1);
            default: return CFG_DATA_W'((1 << DIST_W) - 1);
        endcase
    endfunction

    // Build the control points of one action and queue its samples
    task automatic predict_path(input logic [S_TDATA_W-1:0] word);
        longint  act [NUM_ACTS];
        longint  ctrl [NUM_ACTS];
        longint  n, n3, k, r, b1, b2, b3, px, py;
        t_sample s;
        int      i;
        for (i = 0; i < NUM_ACTS; i++) begin
            act[i] = longint'($signed(word[i*ACT_W +: ACT_W]));
            if (CLIP_ACTIONS) begin
                if (act[i] > Q_ONE) act[i] = Q_ONE;
                if (act[i] < -Q_ONE) act[i] = -Q_ONE;
            end
        end

        // Forward x with floors, each saturated before the next uses it
        ctrl[0] = reg_num(REG_ANCHOR_NEAR) + scale_action(act[0], REG_X_GAIN);
        if (ctrl[0] < reg_num(REG_MIN_FORWARD)) ctrl[0] = reg_num(REG_MIN_FORWARD);
        ctrl[0] = clamp_coord(ctrl[0]);
        ctrl[2] = reg_num(REG_ANCHOR_MID) + scale_action(act[2], REG_X_GAIN);
        if (ctrl[2] < ctrl[0] + reg_num(REG_MIN_GAP)) ctrl[2] = ctrl[0] + reg_num(REG_MIN_GAP);
        ctrl[2] = clamp_coord(ctrl[2]);
        ctrl[4] = reg_num(REG_ANCHOR_FAR) + scale_action(act[4], REG_X_GAIN);
        if (ctrl[4] < ctrl[2] + reg_num(REG_MIN_GAP)) ctrl[4] = ctrl[2] + reg_num(REG_MIN_GAP);
        ctrl[4] = clamp_coord(ctrl[4]);
        ctrl[1] = clamp_coord(scale_action(act[1], REG_LAT_GAIN));
        ctrl[3] = clamp_coord(scale_action(act[3], REG_LAT_GAIN));
        ctrl[5] = clamp_coord(scale_action(act[5], REG_LAT_GAIN));

        n = reg_num(REG_POINT_COUNT);
        if (n < MIN_POINTS) n = MIN_POINTS;
        if (n > MAX_POINTS) n = MAX_POINTS;
        n3 = n * n * n;

        // Bernstein weights with the origin as start point
        for (i = 0; i < n; i++) begin
            k  = i + 1;
            r  = n - k;
            b1 = 3 * r * r * k;
            b2 = 3 * r * k * k;
            b3 = k * k * k;
            px = clamp_coord(round_div(b1 * ctrl[0] + b2 * ctrl[2] + b3 * ctrl[4], n3));
            py = clamp_coord(round_div(b1 * ctrl[1] + b2 * ctrl[3] + b3 * ctrl[5], n3));
            s.idx  = i[IDX_W-1:0];
            s.x    = px[COORD_W-1:0];
            s.y    = py[COORD_W-1:0];
            s.last = (k == n);
            path_queue.insert(path_queue.size(), s);
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic [S_TDATA_W-1:0] action_word(
        input logic [ACT_W-1:0] xn, input logic [ACT_W-1:0] yn,
        input logic [ACT_W-1:0] xm, input logic [ACT_W-1:0] ym,
        input logic [ACT_W-1:0] xf, input logic [ACT_W-1:0] yf
    );
        return {yf, xf, ym, xm, yn, xn};
    endfunction

    // Mostly in-range actions, some beyond the clip range, some extremes
    function automatic logic [ACT_W-1:0] random_action();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(4))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'hC000;
                3: return 16'h4000;
                default: return 16'h0000;
            endcase
        end else if (pick < 30) begin
            return ACT_W'($urandom_range(16'hFFFF));
        end
        return ACT_W'($urandom_range(2 * Q_ONE) - Q_ONE);
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_word();
        logic [S_TDATA_W-1:0] word;
        int                   i;
        for (i = 0; i < NUM_ACTS; i++) begin
            word[i*ACT_W +: ACT_W] = random_action();
        end
        return word;
    endfunction

    function automatic t_cfg_word default_config();
        t_cfg_word v;
        v[REG_POINT_COUNT] = CFG_DATA_W'(RST_POINT_COUNT);
        v[REG_ANCHOR_NEAR] = CFG_DATA_W'(RST_ANCHOR_NEAR);
        v[REG_ANCHOR_MID]  = CFG_DATA_W'(RST_ANCHOR_MID);
        v[REG_ANCHOR_FAR]  = CFG_DATA_W'(RST_ANCHOR_FAR);
        v[REG_X_GAIN]      = RST_X_GAIN;
        v[REG_LAT_GAIN]    = RST_LAT_GAIN;
        v[REG_MIN_GAP]     = CFG_DATA_W'(RST_MIN_GAP);
        v[REG_MIN_FORWARD] = CFG_DATA_W'(RST_MIN_FORWARD);
        return v;
    endfunction

    // Near the default half the time, else anywhere, zero or full scale
    function automatic logic [CFG_DATA_W-1:0] pick_value(input int dflt, input int maxv);
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 50) begin
            v = $urandom_range(2 * dflt);
            if (v > maxv) v = maxv;
        end else if (pick < 80) begin
            v = $urandom_range(maxv);
        end else if (pick < 90) begin
            v = 0;
        end else begin
            v = maxv;
        end
        return CFG_DATA_W'(v);
    endfunction

    function automatic t_cfg_word random_config();
        t_cfg_word v;
        int        pick;
        int        i;
        pick = $urandom_range(99);
        if (pick < 70) begin
            v[REG_POINT_COUNT] = CFG_DATA_W'($urandom_range(8, MIN_POINTS));
        end else if (pick < 85) begin
            v[REG_POINT_COUNT] = CFG_DATA_W'($urandom_range(MAX_POINTS - 1, 9));
        end else if (pick < 90) begin
            v[REG_POINT_COUNT] = CFG_DATA_W'(MAX_POINTS);
        end else if (pick < 95) begin
            v[REG_POINT_COUNT] = CFG_DATA_W'($urandom_range(1, 0));
        end else begin
            v[REG_POINT_COUNT] = CFG_DATA_W'($urandom_range(127, MAX_POINTS + 1));
        end
        // Junk above the register width must be dropped by the block
        v[REG_POINT_COUNT][CFG_DATA_W-1:CNT_W] = (CFG_DATA_W-CNT_W)'($urandom_range(511));
        v[REG_ANCHOR_NEAR] = pick_value(int'(RST_ANCHOR_NEAR), 32767);
        v[REG_ANCHOR_MID]  = pick_value(int'(RST_ANCHOR_MID), 32767);
        v[REG_ANCHOR_FAR]  = pick_value(int'(RST_ANCHOR_FAR), 32767);
        v[REG_X_GAIN]      = pick_value(int'(RST_X_GAIN), 65535);
        v[REG_LAT_GAIN]    = pick_value(int'(RST_LAT_GAIN), 65535);
        v[REG_MIN_GAP]     = pick_value(int'(RST_MIN_GAP), 32767);
        v[REG_MIN_FORWARD] = pick_value(int'(RST_MIN_FORWARD), 32767);
        for (i = REG_ANCHOR_NEAR; i <= REG_MIN_FORWARD; i++) begin
            if (i != REG_X_GAIN && i != REG_LAT_GAIN) v[i][DIST_W] = 1'($urandom_range(1));
        end
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Offer one item after an optional gap; predict once accepted
    task automatic send_action(input logic [S_TDATA_W-1:0] word);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tdata  <= word;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        predict_path(word);
    endtask

    // Stop offering and wait until every queued sample has come out
    task automatic wait_for_paths();
        i_s_axis_tvalid <= 1'b0;
        while (path_queue.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Write all registers back to back while the block is idle
    task automatic apply_config(input t_cfg_word v);
        int i;
        wait_for_paths();
        for (i = 0; i < 8; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= t_reg_idx'(i);
            i_cfg_data  <= v[i];
            @(posedge i_clk);
            reg_val[i] = v[i] & reg_mask(i);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Receiver: long hold-off when asked, else random stalls
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_off_left   <= hold_off_left - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Result check
    // ---------------------------------------------------------------

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_sample got;
        t_sample want;
        if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1) begin
            got.idx  = o_m_axis_tdata[IDX_W-1:0];
            got.x    = o_m_axis_tdata[IDX_W +: COORD_W];
            got.y    = o_m_axis_tdata[IDX_W+COORD_W +: COORD_W];
            got.last = o_m_axis_tlast;
            if (path_queue.size() == 0) begin
                log_failure($sformatf("unexpected sample: idx %0d x %0d y %0d last %0b",
                    got.idx, $signed(got.x), $signed(got.y), got.last));
            end else begin
                want = path_queue.pop_front();
                if (got.idx !== want.idx || got.x !== want.x || got.y !== want.y
                        || got.last !== want.last) begin
                    log_failure($sformatf({"sample mismatch: exp idx %0d x %0d y %0d last %0b,",
                        " got idx %0d x %0d y %0d last %0b"},
                        want.idx, $signed(want.x), $signed(want.y), want.last,
                        got.idx, $signed(got.x), $signed(got.y), got.last));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Register defaults straight out of reset
    task automatic test_reset_defaults();
        send_action(action_word(0, 0, 0, 0, 0, 0));
        send_action({NUM_ACTS{16'h4000}});
        send_action({NUM_ACTS{16'hC000}});
    endtask

    // Actions beyond the clip range and at the field limits
    task automatic test_action_extremes();
        send_action({NUM_ACTS{16'h7FFF}});
        send_action({NUM_ACTS{16'h8000}});
        send_action(action_word(16'h4001, 16'hBFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001));
    endtask

    // Sample counts below two, at the limits, and above the maximum
    task automatic test_point_count_limits();
        t_cfg_word cfg;
        int        counts [6];
        int        i;
        counts = '{0, 1, MIN_POINTS, MAX_POINTS, MAX_POINTS + 1, 127};
        for (i = 0; i < 6; i++) begin
            cfg = default_config();
            cfg[REG_POINT_COUNT] = CFG_DATA_W'(counts[i]);
            if (i == 5) cfg[REG_POINT_COUNT][CFG_DATA_W-1:CNT_W] = '1;
            apply_config(cfg);
            send_action(random_word());
        end
    endtask

    // Floors, saturation of x, zero and full gains, rounding of halves
    task automatic test_control_floors();
        t_cfg_word cfg;
        cfg = default_config();
        cfg[REG_POINT_COUNT] = 8;
        cfg[REG_MIN_FORWARD] = 16'hFFFF;
        cfg[REG_MIN_GAP]     = 16'hFFFF;
        apply_config(cfg);
        send_action(random_word());

        cfg = default_config();
        cfg[REG_POINT_COUNT] = 5;
        cfg[REG_ANCHOR_NEAR] = 16'h7FFF;
        cfg[REG_ANCHOR_MID]  = 16'h7FFF;
        cfg[REG_ANCHOR_FAR]  = 16'h7FFF;
        cfg[REG_X_GAIN]      = 16'hFFFF;
        cfg[REG_LAT_GAIN]    = 16'hFFFF;
        apply_config(cfg);
        send_action(action_word(16'h7FFF, 16'h7FFF, 16'h4000, 16'h8000, 16'h7FFF, 16'hC000));

        cfg = default_config();
        cfg[REG_POINT_COUNT] = 6;
        cfg[REG_ANCHOR_NEAR] = 0;
        cfg[REG_ANCHOR_MID]  = 0;
        cfg[REG_ANCHOR_FAR]  = 0;
        cfg[REG_X_GAIN]      = 16'hFFFF;
        cfg[REG_MIN_GAP]     = 0;
        cfg[REG_MIN_FORWARD] = 0;
        apply_config(cfg);
        send_action({NUM_ACTS{16'hC000}});

        cfg[REG_X_GAIN]   = 0;
        cfg[REG_LAT_GAIN] = 0;
        apply_config(cfg);
        send_action(random_word());

        // Product of exactly one half rounds up, minus one half rounds to zero
        cfg = default_config();
        cfg[REG_POINT_COUNT] = 4;
        cfg[REG_X_GAIN]      = 16'h8000;
        cfg[REG_LAT_GAIN]    = 16'h8000;
        apply_config(cfg);
        send_action(action_word(4, 4, -4, -4, 4, -4));
    endtask

    // Long output hold-off with the sender pushing, then a full drain
    task automatic test_output_hold_off();
        t_cfg_word cfg;
        cfg = default_config();
        cfg[REG_POINT_COUNT] = MAX_POINTS;
        apply_config(cfg);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_left = 600;
        repeat (6) send_action(random_word());
        wait_for_paths();
    endtask

    task automatic run_random_phase(input int idle_s, input int stall_r, input int items);
        send_idle_pct = idle_s;
        stall_pct     = stall_r;
        repeat (4) begin
            apply_config(random_config());
            repeat (items / 4) send_action(random_word());
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 112);
        run_random_phase(81, 0, 112);
        run_random_phase(0, 81, 112);
        run_random_phase(16, 16, 112);
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        t_cfg_word rst_cfg;
        int        i;
        rst_cfg = default_config();
        for (i = 0; i < 8; i++) reg_val[i] = rst_cfg[i];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_action_extremes();
        test_point_count_limits();
        test_control_floors();
        test_output_hold_off();
        test_random_traffic();
        wait_for_paths();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
